### hw/rtl/distinct_prime_factors_core_defines.svh
// Assertion macros shared by the RTL of the prime factor core.
`ifndef DISTINCT_PRIME_FACTORS_CORE_DEFINES_SVH
`define DISTINCT_PRIME_FACTORS_CORE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock, ignored while in reset.
`define DPF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dpf: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock, ignored while in reset.
`define DPF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dpf: next-cycle check failed");

`endif

### hw/rtl/dpf_pkg.sv
package dpf_pkg;

    // Largest number of result beats produced for one input item.
    localparam int MAX_RESULTS = 9;
    localparam int K_W         = 4;
    localparam logic [K_W-1:0] K_MAX = K_W'(MAX_RESULTS);

    // Status codes carried with every result beat.
    localparam logic [1:0] STATUS_FACTOR  = 2'd0;
    localparam logic [1:0] STATUS_NONE    = 2'd1;
    localparam logic [1:0] STATUS_INVALID = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVEN,
        ST_TRY,
        ST_WAIT,
        ST_TAIL,
        ST_FLUSH
    } t_state;

    // Handshake between the sequencer and the shared divider.
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

### hw/rtl/dpf_div.sv
module dpf_div #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output dpf_pkg::t_div_stat o_stat,
    output logic [WIDTH-1:0] o_quot,
    output logic [WIDTH-1:0] o_rem
);

    localparam int CW = $clog2(WIDTH + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [WIDTH-1:0] r_rem;
    logic [WIDTH-1:0] r_quo;
    logic [WIDTH-1:0] r_div;

    logic [WIDTH:0]   w_trial;
    logic [WIDTH:0]   w_diff;
    logic             w_ge;

    // One restoring step per cycle: bring down the next dividend bit.
    assign w_trial = {r_rem, r_quo[WIDTH-1]};
    assign w_diff  = w_trial - {1'b0, r_div};
    assign w_ge    = (w_trial >= {1'b0, r_div});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[WIDTH-1:0] : w_trial[WIDTH-1:0];
            r_quo <= {r_quo[WIDTH-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_quo;
    assign o_rem       = r_rem;

endmodule

### hw/rtl/distinct_prime_factors_core.sv
// Values 0 and 1 give their single beat in the cycle after start.
// Throughput: one item at a time; busy stays high until the last beat has been issued.
// The shared one-bit-per-cycle divider sets the time per trial divisor.
// Reset: i_rst_n is synchronous and active low; it returns the sequencer to idle.
// Result beats cannot be stalled: each is valid for exactly one cycle on o_valid.

`include "distinct_prime_factors_core_defines.svh"

module distinct_prime_factors_core #(
    parameter int WIDTH = 32
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_value,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_factor,
    output logic [1:0]       o_status,
    output logic             o_last
);

    // The sequencer first strips the factor two with a plain shift, then walks the
    // odd trial divisors 3, 5, 7 and so on. Every trial is a single pass through the
    // shared divider, which returns both the quotient and the remainder. The loop
    // ends once the divisor exceeds the quotient (the same test as the divisor
    // squared exceeding the remaining value) or the factor count reaches its limit.
    //
    // Because the last flag is only known once the search has finished, each factor
    // found is held back in a pending register. Finding the next factor releases the
    // pending one as a beat with last low; the end of the search releases it with
    // last high.

    dpf_pkg::t_state    r_state;
    dpf_pkg::t_state    n_state;

    logic [WIDTH-1:0]   r_n;
    logic [WIDTH-1:0]   n_n;
    logic [WIDTH-1:0]   r_d;
    logic [WIDTH-1:0]   n_d;
    logic               r_inner;
    logic               n_inner;
    logic [dpf_pkg::K_W-1:0] r_k;
    logic [dpf_pkg::K_W-1:0] n_k;
    logic [WIDTH-1:0]   r_pend;
    logic [WIDTH-1:0]   n_pend;
    logic               r_pend_valid;
    logic               n_pend_valid;

    logic               r_out_valid;
    logic               n_out_valid;
    logic [WIDTH-1:0]   r_out_factor;
    logic [WIDTH-1:0]   n_out_factor;
    logic [1:0]         r_out_status;
    logic [1:0]         n_out_status;
    logic               r_out_last;
    logic               n_out_last;

    logic               w_div_start;
    dpf_pkg::t_div_stat w_div_stat;
    logic [WIDTH-1:0]   w_quot;
    logic [WIDTH-1:0]   w_rem;
    logic               w_rem_zero;
    logic               w_past_root;

    dpf_div #(
        .WIDTH (WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_n),
        .i_divisor  (r_d),
        .o_stat     (w_div_stat),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    assign w_rem_zero  = (w_rem == '0);
    assign w_past_root = (r_d > w_quot);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            dpf_pkg::ST_IDLE: begin
                if (start && (i_value > WIDTH'(1))) begin
                    n_state = i_value[0] ? dpf_pkg::ST_TRY : dpf_pkg::ST_EVEN;
                end
            end
            dpf_pkg::ST_EVEN: begin
                if (r_n[0]) begin
                    n_state = dpf_pkg::ST_TRY;
                end
            end
            dpf_pkg::ST_TRY: begin
                n_state = (r_k == dpf_pkg::K_MAX) ? dpf_pkg::ST_FLUSH : dpf_pkg::ST_WAIT;
            end
            dpf_pkg::ST_WAIT: begin
                if (w_div_stat.done) begin
                    n_state = (!r_inner && w_past_root) ? dpf_pkg::ST_TAIL : dpf_pkg::ST_TRY;
                end
            end
            dpf_pkg::ST_TAIL: begin
                n_state = dpf_pkg::ST_FLUSH;
            end
            dpf_pkg::ST_FLUSH: begin
                n_state = dpf_pkg::ST_IDLE;
            end
            default: begin
                n_state = dpf_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer.
    always_comb begin
        busy        = (r_state != dpf_pkg::ST_IDLE);
        w_div_start = (r_state == dpf_pkg::ST_TRY) && (r_k != dpf_pkg::K_MAX);
    end

    // Datapath updates and result beats.
    always_comb begin
        n_n          = r_n;
        n_d          = r_d;
        n_inner      = r_inner;
        n_k          = r_k;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out_valid  = 1'b0;
        n_out_factor = r_pend;
        n_out_status = dpf_pkg::STATUS_FACTOR;
        n_out_last   = 1'b0;
        case (r_state)
            dpf_pkg::ST_IDLE: begin
                if (start) begin
                    n_n          = i_value;
                    n_d          = WIDTH'(3);
                    n_inner      = 1'b0;
                    n_k          = '0;
                    n_pend_valid = 1'b0;
                    if (i_value == '0) begin
                        n_out_valid  = 1'b1;
                        n_out_factor = '0;
                        n_out_status = dpf_pkg::STATUS_INVALID;
                        n_out_last   = 1'b1;
                    end else if (i_value == WIDTH'(1)) begin
                        n_out_valid  = 1'b1;
                        n_out_factor = '0;
                        n_out_status = dpf_pkg::STATUS_NONE;
                        n_out_last   = 1'b1;
                    end else if (!i_value[0]) begin
                        n_pend       = WIDTH'(2);
                        n_pend_valid = 1'b1;
                        n_k          = dpf_pkg::K_W'(1);
                    end
                end
            end
            dpf_pkg::ST_EVEN: begin
                if (!r_n[0]) begin
                    n_n = r_n >> 1;
                end
            end
            dpf_pkg::ST_WAIT: begin
                if (w_div_stat.done) begin
                    if (r_inner) begin
                        if (w_rem_zero) begin
                            n_n = w_quot;
                        end else begin
                            n_inner = 1'b0;
                            n_d     = r_d + WIDTH'(2);
                        end
                    end else if (!w_past_root) begin
                        if (w_rem_zero) begin
                            n_out_valid  = r_pend_valid;
                            n_pend       = r_d;
                            n_pend_valid = 1'b1;
                            n_k          = r_k + dpf_pkg::K_W'(1);
                            n_n          = w_quot;
                            n_inner      = 1'b1;
                        end else begin
                            n_d = r_d + WIDTH'(2);
                        end
                    end
                end
            end
            dpf_pkg::ST_TAIL: begin
                // A remaining value above one is the largest prime factor.
                if ((r_n > WIDTH'(1)) && (r_k != dpf_pkg::K_MAX)) begin
                    n_out_valid  = r_pend_valid;
                    n_pend       = r_n;
                    n_pend_valid = 1'b1;
                    n_k          = r_k + dpf_pkg::K_W'(1);
                end
            end
            dpf_pkg::ST_FLUSH: begin
                n_out_valid  = r_pend_valid;
                n_out_last   = 1'b1;
                n_pend_valid = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= dpf_pkg::ST_IDLE;
            r_inner      <= 1'b0;
            r_k          <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_inner      <= n_inner;
            r_k          <= n_k;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n          <= n_n;
        r_d          <= n_d;
        r_pend       <= n_pend;
        r_out_factor <= n_out_factor;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
    end

    assign o_valid  = r_out_valid;
    assign o_factor = r_out_factor;
    assign o_status = r_out_status;
    assign o_last   = r_out_last;

    // A beat that carries no factor is always the only beat of its item.
    `DPF_ASSERT_NOW(a_status_last, i_clk, i_rst_n,
        r_out_valid && (r_out_status != dpf_pkg::STATUS_FACTOR), r_out_last)
    // The divider only reports a result while the sequencer is waiting for one.
    `DPF_ASSERT_NOW(a_div_done_wait, i_clk, i_rst_n,
        w_div_stat.done, r_state == dpf_pkg::ST_WAIT)
    // The factor count never runs past the result limit.
    `DPF_ASSERT_NOW(a_k_bound, i_clk, i_rst_n, 1'b1, r_k <= dpf_pkg::K_MAX)
    // Leaving the flush step always issues the closing beat of the item.
    `DPF_ASSERT_NEXT(a_flush_last, i_clk, i_rst_n,
        r_state == dpf_pkg::ST_FLUSH, r_out_valid && r_out_last)

endmodule
